### design/hsfd_pkg.sv
// Shared types, constants and arithmetic helpers for the humidity sensor frame decoder.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package hsfd_pkg;

    localparam logic [7:0]         CRC_INIT   = 8'hFF;
    localparam logic [7:0]         CRC_POLY   = 8'h31;
    localparam logic [14:0]        TEMP_SCALE = 15'd17500;
    localparam logic [13:0]        HUM_SCALE  = 14'd10000;
    localparam logic signed [15:0] TEMP_BIAS  = 16'sd4500;
    localparam logic signed [15:0] TEMP_LOW   = -16'sd6500;
    localparam logic signed [15:0] TEMP_HIGH  = 16'sd15000;

    // Position of the next byte within the six-byte frame
    typedef enum logic [5:0] {
        POS_T_HI  = 6'b000001,
        POS_T_LO  = 6'b000010,
        POS_T_CRC = 6'b000100,
        POS_H_HI  = 6'b001000,
        POS_H_LO  = 6'b010000,
        POS_H_CRC = 6'b100000
    } t_pos;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_BAD = 2'd1,
        STATUS_HUM_BAD  = 2'd2
    } t_status;

    // Frame tracker -> conversion unit
    typedef struct packed {
        logic        temp_word_done;
        logic        last;
        t_status     status;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
    } t_frame_evt;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        c = acc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // floor(p / 65535) for p < 2^31: p = q0*65535 + (q0 + lo), remainder below 2*65535
    function automatic logic [14:0] div65535(input logic [30:0] p);
        logic [14:0] q0;
        logic [16:0] r;
        q0 = p[30:16];
        r  = {1'b0, p[15:0]} + {2'b00, q0};
        return q0 + {14'd0, (r >= 17'd65535)};
    endfunction

endpackage

### design/hsfd_in_if.sv
// Input byte channel of the frame decoder.
// Depends on hsfd_pkg.
`timescale 1ns / 1ps

interface hsfd_in_if import hsfd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_begin;

    modport source (output valid, output rx_byte, output frame_begin, input ready);
    modport sink   (input valid, input rx_byte, input frame_begin, output ready);
endinterface

### design/hsfd_out_if.sv
// Result channel of the frame decoder.
// Depends on hsfd_pkg.
`timescale 1ns / 1ps

interface hsfd_out_if import hsfd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [1:0]         status;

    modport source (output valid, output temperature_centi, output humidity_centi,
                    output status, input ready);
    modport sink   (input valid, input temperature_centi, input humidity_centi,
                    input status, output ready);
endinterface

### design/hsfd_cfg_if.sv
// Configuration write channel: temperature offset register.
// Depends on hsfd_pkg.
`timescale 1ns / 1ps

interface hsfd_cfg_if import hsfd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [11:0] temperature_offset;

    modport source (output valid, output temperature_offset, input ready);
    modport sink   (input valid, input temperature_offset, output ready);
endinterface

### design/hsfd_frame.sv
// Frame tracker: byte position, running CRC, captured words and CRC verdicts.
// Depends on hsfd_pkg.
`timescale 1ns / 1ps

module hsfd_frame import hsfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_begin,
    output t_frame_evt o_evt
);

    t_pos        r_pos,       n_pos;
    logic [7:0]  r_crc,       n_crc;
    logic [15:0] r_temp_word, n_temp_word;
    logic [15:0] r_hum_word,  n_hum_word;
    logic        r_temp_bad,  n_temp_bad;
    t_pos        w_pos;

    always_comb begin
        w_pos       = i_begin ? POS_T_HI : r_pos;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_temp_word = r_temp_word;
        n_hum_word  = r_hum_word;
        n_temp_bad  = r_temp_bad;
        o_evt.temp_word_done = 1'b0;
        o_evt.last           = 1'b0;
        o_evt.status         = STATUS_OK;
        o_evt.temp_word      = r_temp_word;
        o_evt.hum_word       = r_hum_word;
        unique case (w_pos)
            POS_T_LO: begin
                n_crc       = crc8_update(r_crc, i_byte);
                n_temp_word = {r_temp_word[15:8], i_byte};
                n_pos       = POS_T_CRC;
            end
            POS_T_CRC: begin
                n_temp_bad = (r_crc != i_byte);
                n_crc      = CRC_INIT;
                n_pos      = POS_H_HI;
                o_evt.temp_word_done = 1'b1;
            end
            POS_H_HI: begin
                n_crc      = crc8_update(CRC_INIT, i_byte);
                n_hum_word = {i_byte, 8'h00};
                n_pos      = POS_H_LO;
            end
            POS_H_LO: begin
                n_crc      = crc8_update(r_crc, i_byte);
                n_hum_word = {r_hum_word[15:8], i_byte};
                n_pos      = POS_H_CRC;
            end
            POS_H_CRC: begin
                n_crc      = CRC_INIT;
                n_pos      = POS_T_HI;
                o_evt.last = 1'b1;
                // first failing check wins
                if (r_temp_bad) begin
                    o_evt.status = STATUS_TEMP_BAD;
                end else if (r_crc != i_byte) begin
                    o_evt.status = STATUS_HUM_BAD;
                end
            end
            default: begin
                // byte zero, also any unreachable position
                n_crc       = crc8_update(CRC_INIT, i_byte);
                n_temp_word = {i_byte, 8'h00};
                n_pos       = POS_T_LO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_T_HI;
            r_crc       <= CRC_INIT;
            r_temp_word <= '0;
            r_hum_word  <= '0;
            r_temp_bad  <= 1'b0;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_temp_word <= n_temp_word;
            r_hum_word  <= n_hum_word;
            r_temp_bad  <= n_temp_bad;
        end
    end

    a_crc_cleared_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (o_evt.last || o_evt.temp_word_done) |=> r_crc == CRC_INIT)
        else $error("running CRC not restarted after a check byte");

    a_frame_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_evt.last |=> r_pos == POS_T_HI)
        else $error("frame did not wrap to byte zero after the last byte");

    a_begin_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_begin |=> r_pos == POS_T_LO)
        else $error("frame start byte not taken as byte zero");

endmodule

### design/hsfd_conv.sv
// Conversion unit: raw words to centi-degrees and centi-percent, offset and saturation.
// Depends on hsfd_pkg (event struct, scaling constants, div65535).
`timescale 1ns / 1ps

module hsfd_conv import hsfd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_step,
    input  t_frame_evt         i_evt,
    input  logic signed [11:0] i_offset,
    output logic signed [14:0] o_temp_centi,
    output logic [13:0]        o_hum_centi,
    output t_status            o_status
);

    logic [14:0]        r_temp_q;
    logic [30:0]        w_temp_prod;
    logic [30:0]        w_hum_prod;
    logic [14:0]        w_hum_q;
    logic signed [15:0] w_temp_sum;
    logic signed [15:0] w_temp_sat;

    // temperature scaling happens on the temperature CRC byte, leaving the
    // last byte only the offset add and clamp
    assign w_temp_prod = {15'd0, i_evt.temp_word} * {16'd0, TEMP_SCALE};
    assign w_hum_prod  = {15'd0, i_evt.hum_word} * {17'd0, HUM_SCALE};
    assign w_hum_q     = div65535(w_hum_prod);

    always_ff @(posedge i_clk) begin
        if (i_step && i_evt.temp_word_done) begin
            r_temp_q <= div65535(w_temp_prod);
        end
    end

    always_comb begin
        w_temp_sum = $signed({1'b0, r_temp_q}) - TEMP_BIAS
                   + $signed({{4{i_offset[11]}}, i_offset});
        if (w_temp_sum < TEMP_LOW) begin
            w_temp_sat = TEMP_LOW;
        end else if (w_temp_sum > TEMP_HIGH) begin
            w_temp_sat = TEMP_HIGH;
        end else begin
            w_temp_sat = w_temp_sum;
        end
    end

    always_comb begin
        o_status = i_evt.status;
        if (i_evt.status == STATUS_OK) begin
            o_temp_centi = w_temp_sat[14:0];
            o_hum_centi  = w_hum_q[13:0];
        end else begin
            o_temp_centi = '0;
            o_hum_centi  = '0;
        end
    end

    a_temp_q_range: assert property (@(posedge i_clk)
        $past(i_step && i_evt.temp_word_done) |-> r_temp_q <= TEMP_SCALE)
        else $error("scaled temperature above full scale");

    a_hum_range: assert property (@(posedge i_clk)
        i_step && i_evt.last |-> o_hum_centi <= HUM_SCALE)
        else $error("humidity above full scale");

    a_temp_clamped: assert property (@(posedge i_clk)
        i_step && i_evt.last |-> o_temp_centi >= $signed(TEMP_LOW[14:0])
                                 && o_temp_centi <= $signed(TEMP_HIGH[14:0]))
        else $error("temperature outside clamp range");

endmodule

### design/humidity_sensor_frame_decoder_top.sv
// Channel      | Dir | Payload                                        | Transaction
// i_in         | in  | rx_byte[7:0], frame_begin                      | one frame byte
// o_out        | out | temperature_centi[14:0] s, humidity_centi[13:0], status[1:0] | one result
// i_cfg        | in  | temperature_offset[11:0] s                     | offset write
//
// One byte per cycle sustained while the result register is free; the last byte of
// a frame gives its result through the input register, then the result register.
// The result register holds a pending result while the next frame's bytes are
// taken; only a last byte meeting an occupied, stalled result register waits.
// Synchronous active-low reset: frame restarts at byte zero, offset clears to 0.
// Depends on hsfd_pkg, the three channel interfaces, hsfd_frame and hsfd_conv.
`timescale 1ns / 1ps

module humidity_sensor_frame_decoder_top import hsfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsfd_in_if.sink    i_in,
    hsfd_out_if.source o_out,
    hsfd_cfg_if.sink   i_cfg
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_begin;
    logic signed [11:0] r_temp_offset;
    logic               r_out_valid;
    logic signed [14:0] r_out_temp;
    logic [13:0]        r_out_hum;
    t_status            r_out_status;

    t_frame_evt         w_evt;
    logic               w_out_free;
    logic               w_advance;
    logic signed [14:0] w_temp_centi;
    logic [13:0]        w_hum_centi;
    t_status            w_status;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_advance  = r_in_valid && (!w_evt.last || w_out_free);

    assign i_in.ready  = !r_in_valid || w_advance;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid             = r_out_valid;
    assign o_out.temperature_centi = r_out_temp;
    assign o_out.humidity_centi    = r_out_hum;
    assign o_out.status            = r_out_status;

    hsfd_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_byte  (r_in_byte),
        .i_begin (r_in_begin),
        .o_evt   (w_evt)
    );

    hsfd_conv u_conv (
        .i_clk        (i_clk),
        .i_step       (w_advance),
        .i_evt        (w_evt),
        .i_offset     (r_temp_offset),
        .o_temp_centi (w_temp_centi),
        .o_hum_centi  (w_hum_centi),
        .o_status     (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte  <= i_in.rx_byte;
            r_in_begin <= i_in.frame_begin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_offset <= '0;
        end else if (i_cfg.valid) begin
            r_temp_offset <= i_cfg.temperature_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_evt.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_evt.last) begin
            r_out_temp   <= w_temp_centi;
            r_out_hum    <= w_hum_centi;
            r_out_status <= w_status;
        end
    end

    a_fail_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != STATUS_OK |-> r_out_temp == '0 && r_out_hum == '0)
        else $error("failed frame carries nonzero values");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_begin))
        else $error("stalled byte lost from input register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !(w_advance && w_evt.last))
        else $error("pending result overwritten");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_status == STATUS_OK || r_out_status == STATUS_TEMP_BAD
                        || r_out_status == STATUS_HUM_BAD)
        else $error("undefined status code on result");

endmodule
